[rtl/core/skrt_pkg.sv]
// Shared types and codes for the sorted key record table.
`timescale 1ns / 1ps

package skrt_pkg;

  localparam int unsigned KindW    = 3;
  localparam int unsigned KeyW     = 20;
  localparam int unsigned DayW     = 5;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned YearW    = 14;
  localparam int unsigned CreditsW = 14;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned PosW     = 6;

  localparam logic [KindW-1:0] KIND_INSERT = 3'd0;
  localparam logic [KindW-1:0] KIND_UPDATE = 3'd1;
  localparam logic [KindW-1:0] KIND_REMOVE = 3'd2;
  localparam logic [KindW-1:0] KIND_SEARCH = 3'd3;
  localparam logic [KindW-1:0] KIND_LIST   = 3'd4;

  localparam logic [StatusW-1:0] STATUS_OK        = 3'd0;
  localparam logic [StatusW-1:0] STATUS_NOT_FOUND = 3'd1;
  localparam logic [StatusW-1:0] STATUS_FULL      = 3'd2;
  localparam logic [StatusW-1:0] STATUS_DUP       = 3'd3;
  localparam logic [StatusW-1:0] STATUS_EMPTY     = 3'd4;

  typedef struct packed {
    logic [KeyW-1:0]     key;
    logic [DayW-1:0]     day;
    logic [MonthW-1:0]   month;
    logic [YearW-1:0]    year;
    logic [CreditsW-1:0] credits;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_UPDATE,
    CMD_REMOVE,
    CMD_ROTATE
  } cell_cmd_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_cmd_e cmd;
    entry_t    req;
  } cell_ctrl_t;

  // Per-cell status seen by the controller and the neighbors.
  typedef struct packed {
    logic valid;
    logic lt;
    logic ge;
    logic match;
  } cell_flag_t;

endpackage

[rtl/core/skrt_cell.sv]
// One storage cell of the sorted record row.
`timescale 1ns / 1ps

module skrt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  skrt_pkg::cell_ctrl_t ctrl_i,
  input  skrt_pkg::entry_t    prev_ent_i,
  input  logic                prev_valid_i,
  input  logic                prev_lt_i,
  input  skrt_pkg::entry_t    next_ent_i,
  input  logic                next_valid_i,
  input  skrt_pkg::entry_t    head_ent_i,
  output skrt_pkg::entry_t    ent_o,
  output skrt_pkg::cell_flag_t flag_o
);
  import skrt_pkg::*;

  entry_t ent_q, ent_d;
  logic   valid_q, valid_d;

  // The row stays sorted, so key compares against the request give the
  // insertion and removal boundaries without any carry chain.
  assign flag_o.valid = valid_q;
  assign flag_o.lt    = valid_q && (ent_q.key <  ctrl_i.req.key);
  assign flag_o.ge    = valid_q && (ent_q.key >= ctrl_i.req.key);
  assign flag_o.match = valid_q && (ent_q.key == ctrl_i.req.key);
  assign ent_o        = ent_q;

  always_comb begin
    ent_d   = ent_q;
    valid_d = valid_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (!flag_o.lt) begin
          if (prev_lt_i) begin
            ent_d   = ctrl_i.req;
            valid_d = 1'b1;
          end else begin
            ent_d   = prev_ent_i;
            valid_d = prev_valid_i;
          end
        end
      end
      CMD_UPDATE: begin
        if (flag_o.match) begin
          ent_d = ctrl_i.req;
        end
      end
      CMD_REMOVE: begin
        if (flag_o.ge) begin
          ent_d   = next_ent_i;
          valid_d = next_valid_i;
        end
      end
      CMD_ROTATE: begin
        if (valid_q) begin
          ent_d = next_valid_i ? next_ent_i : head_ent_i;
        end
      end
      default: begin
        ent_d   = ent_q;
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

[rtl/core/skrt_select.sv]
// One-hot selector that returns the chosen cell's record and index.
`timescale 1ns / 1ps

module skrt_select #(
  parameter int unsigned N = 64
) (
  input  logic [N-1:0]         sel_i,
  input  skrt_pkg::entry_t     ent_i [N],
  output logic                 hit_o,
  output skrt_pkg::entry_t     ent_o,
  output logic [$clog2(N)-1:0] idx_o
);
  import skrt_pkg::*;

  localparam int unsigned IdxW = $clog2(N);

  always_comb begin
    ent_o = '0;
    idx_o = '0;
    for (int i = 0; i < N; i++) begin
      if (sel_i[i]) begin
        ent_o = ent_o | ent_i[i];
        idx_o = idx_o | IdxW'(i);
      end
    end
  end

  assign hit_o = |sel_i;

endmodule

[rtl/core/sorted_key_record_table.sv]
// Top level of the sorted key record table: controller and cell row.
`timescale 1ns / 1ps

// The table keeps up to TABLE_DEPTH records in a row of cells, always in
// ascending key order with the valid cells packed from cell 0. A request is
// taken when start_i is high and busy_o is low. Insert, update, remove and
// search compare the request key in every cell at once in the execute
// cycle, in which insert and remove shift the row by one place and update
// rewrites the matching cell. The single result is registered there and is
// on the ports when the next request may already be accepted. List rotates
// the valid part of the row through cell 0 and streams one record per
// cycle; the row is back in order when the last record leaves. An
// empty-table list and every error give one result with zero record fields
// and last_o set. A kind code beyond list is dropped without a result.
// Results are shown for exactly one cycle under valid_o and cannot be held
// off by the receiver. The record storage needs no clearing after reset:
// only cells marked valid are ever read.
module sorted_key_record_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [skrt_pkg::KindW-1:0]     kind_i,
  input  logic [skrt_pkg::KeyW-1:0]      key_i,
  input  logic [skrt_pkg::DayW-1:0]      day_in_i,
  input  logic [skrt_pkg::MonthW-1:0]    month_in_i,
  input  logic [skrt_pkg::YearW-1:0]     year_in_i,
  input  logic [skrt_pkg::CreditsW-1:0]  credits_in_i,
  output logic                           valid_o,
  output logic [skrt_pkg::StatusW-1:0]   status_o,
  output logic [skrt_pkg::PosW-1:0]      position_o,
  output logic [skrt_pkg::KeyW-1:0]      key_out_o,
  output logic [skrt_pkg::DayW-1:0]      day_out_o,
  output logic [skrt_pkg::MonthW-1:0]    month_out_o,
  output logic [skrt_pkg::YearW-1:0]     year_out_o,
  output logic [skrt_pkg::CreditsW-1:0]  credits_out_o,
  output logic                           last_o
);
  import skrt_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LIST
  } state_e;

  state_e            state_q, state_d;
  logic [KindW-1:0]  kind_q, kind_d;
  entry_t            req_q, req_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   list_idx_q, list_idx_d;

  logic              res_valid_q, res_valid_d;
  logic [StatusW-1:0] res_status_q, res_status_d;
  logic [PosW-1:0]   res_pos_q, res_pos_d;
  entry_t            res_ent_q, res_ent_d;
  logic              res_last_q, res_last_d;

  cell_ctrl_t        cell_ctrl;
  entry_t            cell_ent  [TABLE_DEPTH];
  cell_flag_t        cell_flag [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match_vec;
  logic [TABLE_DEPTH-1:0] bound_vec;
  logic [TABLE_DEPTH-1:0] valid_vec;

  logic              found;
  entry_t            found_ent;
  logic [IdxW-1:0]   found_idx;
  logic [IdxW-1:0]   ins_idx;
  logic              list_last;

  // The row of cells. Cell 0 sees an always-lower left neighbor so that an
  // insert below every stored key lands there; the last cell sees an empty
  // right neighbor.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    entry_t prev_ent;
    entry_t next_ent;
    logic   prev_valid;
    logic   prev_lt;
    logic   next_valid;

    if (g == 0) begin : g_head
      assign prev_ent   = cell_ctrl.req;
      assign prev_valid = 1'b0;
      assign prev_lt    = 1'b1;
    end else begin : g_body
      assign prev_ent   = cell_ent[g-1];
      assign prev_valid = cell_flag[g-1].valid;
      assign prev_lt    = cell_flag[g-1].lt;
    end

    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign next_ent   = cell_ent[0];
      assign next_valid = 1'b0;
    end else begin : g_link
      assign next_ent   = cell_ent[g+1];
      assign next_valid = cell_flag[g+1].valid;
    end

    skrt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .prev_ent_i   (prev_ent),
      .prev_valid_i (prev_valid),
      .prev_lt_i    (prev_lt),
      .next_ent_i   (next_ent),
      .next_valid_i (next_valid),
      .head_ent_i   (cell_ent[0]),
      .ent_o        (cell_ent[g]),
      .flag_o       (cell_flag[g])
    );

    // The insertion point is the first cell whose key is not below the
    // request key, empty cells included.
    assign match_vec[g] = cell_flag[g].match;
    assign bound_vec[g] = !cell_flag[g].lt && prev_lt;
    assign valid_vec[g] = cell_flag[g].valid;
  end

  skrt_select #(
    .N (TABLE_DEPTH)
  ) u_match_sel (
    .sel_i (match_vec),
    .ent_i (cell_ent),
    .hit_o (found),
    .ent_o (found_ent),
    .idx_o (found_idx)
  );

  // Only the index of the insertion point is needed, so it is encoded here
  // from the one-hot boundary vector.
  always_comb begin
    ins_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (bound_vec[i]) begin
        ins_idx = ins_idx | IdxW'(i);
      end
    end
  end

  assign list_last = ((CntW'(list_idx_q) + CntW'(1)) == count_q);

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    req_d        = req_q;
    count_d      = count_q;
    list_idx_d   = list_idx_q;
    res_valid_d  = 1'b0;
    res_status_d = STATUS_OK;
    res_pos_d    = '0;
    res_ent_d    = '0;
    res_last_d   = 1'b1;
    cell_ctrl.cmd = CMD_HOLD;
    cell_ctrl.req = req_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          kind_d        = kind_i;
          req_d.key     = key_i;
          req_d.day     = day_in_i;
          req_d.month   = month_in_i;
          req_d.year    = year_in_i;
          req_d.credits = credits_in_i;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        case (kind_q)
          KIND_INSERT: begin
            res_valid_d = 1'b1;
            // A full table is reported ahead of a duplicate key.
            if (count_q == CntW'(TABLE_DEPTH)) begin
              res_status_d = STATUS_FULL;
            end else if (found) begin
              res_status_d = STATUS_DUP;
            end else begin
              cell_ctrl.cmd = CMD_INSERT;
              count_d       = count_q + CntW'(1);
              res_pos_d     = PosW'(ins_idx);
              res_ent_d     = req_q;
            end
          end
          KIND_UPDATE: begin
            res_valid_d = 1'b1;
            if (found) begin
              cell_ctrl.cmd = CMD_UPDATE;
              res_pos_d     = PosW'(found_idx);
              res_ent_d     = req_q;
            end else begin
              res_status_d = STATUS_NOT_FOUND;
            end
          end
          KIND_REMOVE: begin
            res_valid_d = 1'b1;
            if (found) begin
              cell_ctrl.cmd = CMD_REMOVE;
              count_d       = count_q - CntW'(1);
              res_pos_d     = PosW'(found_idx);
              res_ent_d     = found_ent;
            end else begin
              res_status_d = STATUS_NOT_FOUND;
            end
          end
          KIND_SEARCH: begin
            res_valid_d = 1'b1;
            if (found) begin
              res_pos_d = PosW'(found_idx);
              res_ent_d = found_ent;
            end else begin
              res_status_d = STATUS_NOT_FOUND;
            end
          end
          KIND_LIST: begin
            if (count_q == '0) begin
              res_valid_d  = 1'b1;
              res_status_d = STATUS_EMPTY;
            end else begin
              list_idx_d = '0;
              state_d    = ST_LIST;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_LIST: begin
        // Cell 0 always holds the next record to report; the row rotates
        // toward it and closes back on itself after the last one.
        cell_ctrl.cmd = CMD_ROTATE;
        res_valid_d   = 1'b1;
        res_pos_d     = PosW'(list_idx_q);
        res_ent_d     = cell_ent[0];
        res_last_d    = list_last;
        list_idx_d    = list_idx_q + IdxW'(1);
        if (list_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kind_q       <= '0;
      req_q        <= '0;
      count_q      <= '0;
      list_idx_q   <= '0;
      res_valid_q  <= 1'b0;
      res_status_q <= STATUS_OK;
      res_pos_q    <= '0;
      res_ent_q    <= '0;
      res_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      kind_q       <= kind_d;
      req_q        <= req_d;
      count_q      <= count_d;
      list_idx_q   <= list_idx_d;
      res_valid_q  <= res_valid_d;
      res_status_q <= res_status_d;
      res_pos_q    <= res_pos_d;
      res_ent_q    <= res_ent_d;
      res_last_q   <= res_last_d;
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign valid_o       = res_valid_q;
  assign status_o      = res_status_q;
  assign position_o    = res_pos_q;
  assign key_out_o     = res_ent_q.key;
  assign day_out_o     = res_ent_q.day;
  assign month_out_o   = res_ent_q.month;
  assign year_out_o    = res_ent_q.year;
  assign credits_out_o = res_ent_q.credits;
  assign last_o        = res_last_q;

  // The count never exceeds the row length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // The valid cells match the count and stay packed from cell 0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(valid_vec) == count_q) && ((valid_vec & (valid_vec + 1'b1)) == '0))
    else $error("cell valid bits out of step with the entry count");

  // A list stream has no gaps before its final record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> valid_o)
    else $error("list stream broke off before its last record");

  // An accepted request always makes the block busy for its execute cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not enter execution");

endmodule

[test/tb_sorted_key_record_table.sv]
// Self-checking testbench for the sorted key record table.
`timescale 1ns / 1ps

// The testbench feeds requests to the table and checks every result
// against its own copy of the table, which it keeps in key order.
//
// The stimulus process fills a queue of pending requests. A directed
// opening comes first. It covers the empty table, misses on every keyed
// operation, the key and payload extremes, a duplicate insert, removal at
// the head and tail, the unused kind codes, and listing. Random
// requests follow. They are shaped in three moods so that the table really
// fills and drains. Fill is mostly inserts and runs until the table is full
// and several more inserts have bounced off it. Drain is mostly removes of
// keys that are present and runs until the table is empty. Mix is a short
// stretch of everything. Keys come from the set that is live at that point,
// from a small pool that is reused, or from the full key range, so hits,
// misses and duplicates all occur.
//
// A clocked driver takes requests from the queue and holds start_i until
// the table accepts. At the accepting edge the table copy is updated and
// the results are queued. A clocked monitor compares each strobed result,
// field by field, with the oldest result still waiting.
module tb_sorted_key_record_table;
  import skrt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_REQUESTS = 400;
  localparam int unsigned NUM_PHASES = 3;
  localparam int unsigned KEY_POOL_SIZE = 96;
  localparam int unsigned KEY_MAX = (1 << KeyW) - 1;
  // Requests, mostly inserts, that follow a full table before the fill mood ends.
  localparam int unsigned FULL_RETRIES = 8;
  localparam int unsigned MIX_LENGTH = 40;

  typedef struct packed {
    logic [KindW-1:0] kind;
    entry_t           rec;
  } request_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [PosW-1:0]    pos;
    entry_t             rec;
    logic               last;
  } report_t;

  typedef enum logic [1:0] {
    FILL,
    DRAIN,
    MIX
  } stim_mood_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [KindW-1:0]    kind_i = '0;
  logic [KeyW-1:0]     key_i = '0;
  logic [DayW-1:0]     day_in_i = '0;
  logic [MonthW-1:0]   month_in_i = '0;
  logic [YearW-1:0]    year_in_i = '0;
  logic [CreditsW-1:0] credits_in_i = '0;
  logic                valid_o;
  logic [StatusW-1:0]  status_o;
  logic [PosW-1:0]     position_o;
  logic [KeyW-1:0]     key_out_o;
  logic [DayW-1:0]     day_out_o;
  logic [MonthW-1:0]   month_out_o;
  logic [YearW-1:0]    year_out_o;
  logic [CreditsW-1:0] credits_out_o;
  logic                last_o;

  // The testbench's copy of the table: records in ascending key order.
  entry_t      record_table [TABLE_DEPTH];
  int unsigned record_count = 0;
  report_t     expected_reports [$];

  request_t    pending_requests [$];
  request_t    offered_req;
  // Requests pushed but not yet accepted by the table.
  int unsigned open_requests = 0;
  int unsigned sender_idle_pct = 0;
  bit          failed = 1'b0;

  // Keys that the stimulus believes are in the table once every queued
  // request has run. It only steers key choice; checking never uses it.
  logic [KeyW-1:0] live_keys [$];
  logic [KeyW-1:0] key_pool [KEY_POOL_SIZE];

  sorted_key_record_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (.*);

  always #1 clk_i = ~clk_i;

  function automatic int find_record(logic [KeyW-1:0] key);
    for (int i = 0; i < record_count; i++) begin
      if (record_table[i].key == key) return i;
    end
    return -1;
  endfunction

  function automatic void report_entry(int idx, bit last);
    report_t r;
    r.status = STATUS_OK;
    r.pos = PosW'(idx);
    r.rec = record_table[idx];
    r.last = last;
    expected_reports.push_back(r);
  endfunction

  // Every error result carries zero record fields and ends its request.
  function automatic void report_status(logic [StatusW-1:0] code);
    report_t r;
    r = '0;
    r.status = code;
    r.last = 1'b1;
    expected_reports.push_back(r);
  endfunction

  // Applies one accepted request to the table copy and queues its results.
  function automatic void predict_request(request_t req);
    int slot;
    slot = find_record(req.rec.key);
    case (req.kind)
      KIND_INSERT: begin
        // A full table wins over a duplicate key.
        if (record_count == TABLE_DEPTH) begin
          report_status(STATUS_FULL);
        end else if (slot >= 0) begin
          report_status(STATUS_DUP);
        end else begin
          // Walk down from the end, moving larger keys up one place.
          slot = record_count;
          while (slot > 0 && record_table[slot-1].key > req.rec.key) begin
            record_table[slot] = record_table[slot-1];
            slot--;
          end
          record_table[slot] = req.rec;
          record_count++;
          report_entry(slot, 1'b1);
        end
      end
      KIND_UPDATE: begin
        if (slot < 0) begin
          report_status(STATUS_NOT_FOUND);
        end else begin
          record_table[slot].day = req.rec.day;
          record_table[slot].month = req.rec.month;
          record_table[slot].year = req.rec.year;
          record_table[slot].credits = req.rec.credits;
          report_entry(slot, 1'b1);
        end
      end
      KIND_REMOVE: begin
        if (slot < 0) begin
          report_status(STATUS_NOT_FOUND);
        end else begin
          // The result shows the record and the place it had.
          report_entry(slot, 1'b1);
          for (int i = slot; i + 1 < record_count; i++) begin
            record_table[i] = record_table[i+1];
          end
          record_count--;
        end
      end
      KIND_SEARCH: begin
        if (slot < 0) report_status(STATUS_NOT_FOUND);
        else report_entry(slot, 1'b1);
      end
      KIND_LIST: begin
        if (record_count == 0) begin
          report_status(STATUS_EMPTY);
        end else begin
          for (int i = 0; i < record_count; i++) begin
            report_entry(i, i + 1 == record_count);
          end
        end
      end
      default: begin
        // Unused kind codes are dropped without a result.
      end
    endcase
  endfunction

  function automatic int live_slot(logic [KeyW-1:0] key);
    for (int i = 0; i < live_keys.size(); i++) begin
      if (live_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void push_request(logic [KindW-1:0] kind, logic [KeyW-1:0] key,
                                       int unsigned day, int unsigned month,
                                       int unsigned year, int unsigned credits);
    request_t req;
    int       slot;
    req.kind = kind;
    req.rec.key = key;
    req.rec.day = DayW'(day);
    req.rec.month = MonthW'(month);
    req.rec.year = YearW'(year);
    req.rec.credits = CreditsW'(credits);
    pending_requests.push_back(req);
    open_requests++;
    slot = live_slot(key);
    if (kind == KIND_INSERT && slot < 0 && live_keys.size() < TABLE_DEPTH) begin
      live_keys.push_back(key);
    end else if (kind == KIND_REMOVE && slot >= 0) begin
      live_keys.delete(slot);
    end
  endfunction

  // Picks a live key with the given chance, else a pool or fully random key.
  function automatic logic [KeyW-1:0] pick_key(int unsigned hit_pct);
    if (live_keys.size() != 0 && $urandom_range(0, 99) < hit_pct) begin
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    end
    if ($urandom_range(0, 1) == 1) return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    return KeyW'($urandom_range(0, KEY_MAX));
  endfunction

  // The driver holds a request on the ports until the table takes it. It
  // samples busy_o as it was before the edge, so the accept decision
  // matches the one that the table makes at the same edge.
  always @(posedge clk_i) begin : driver
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predict_request(offered_req);
        open_requests--;
      end
      if (!(start_i && busy_o)) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          offered_req = pending_requests.pop_front();
          start_i <= 1'b1;
          kind_i <= offered_req.kind;
          key_i <= offered_req.rec.key;
          day_in_i <= offered_req.rec.day;
          month_in_i <= offered_req.rec.month;
          year_in_i <= offered_req.rec.year;
          credits_in_i <= offered_req.rec.credits;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Results cannot be held off, so every strobed cycle is one result.
  always @(posedge clk_i) begin : monitor
    report_t want;
    if (rst_ni && valid_o) begin
      if (expected_reports.size() == 0) begin
        $error("result with key %0d arrived with none expected", key_out_o);
        failed = 1'b1;
      end else begin
        want = expected_reports.pop_front();
        check_field("status", want.status, status_o);
        check_field("position", want.pos, position_o);
        check_field("key_out", want.rec.key, key_out_o);
        check_field("day_out", want.rec.day, day_out_o);
        check_field("month_out", want.rec.month, month_out_o);
        check_field("year_out", want.rec.year, year_out_o);
        check_field("credits_out", want.rec.credits, credits_out_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[sorted_key_record_table] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned made;
    int unsigned full_left;
    int unsigned mix_left;
    int unsigned roll;
    int unsigned ins_pct;
    int unsigned rem_pct;
    logic [KindW-1:0] kind;
    logic [KeyW-1:0]  key;
    stim_mood_e mood;

    for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = KeyW'($urandom_range(0, KEY_MAX));
    key_pool[0] = '0;
    key_pool[1] = KeyW'(KEY_MAX);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: the empty table first, then a handful of records.
    push_request(KIND_LIST, 0, 0, 0, 0, 0);
    push_request(KIND_SEARCH, 5, 0, 0, 0, 0);
    push_request(KIND_UPDATE, 5, 7, 7, 2000, 10);
    push_request(KIND_REMOVE, 5, 0, 0, 0, 0);
    push_request(KIND_INSERT, 500, 31, 12, 9999, 9999);
    push_request(KIND_INSERT, 0, 1, 1, 0, 0);
    // Payload fields at all ones, beyond their nominal ranges.
    push_request(KIND_INSERT, KEY_MAX, 31, 15, 16383, 16383);
    push_request(KIND_INSERT, 999999, 0, 0, 0, 0);
    push_request(KIND_INSERT, 500, 2, 2, 2, 2);
    push_request(KIND_INSERT, 250, 15, 6, 1999, 42);
    push_request(KIND_SEARCH, 250, 0, 0, 0, 0);
    push_request(KIND_SEARCH, KEY_MAX, 0, 0, 0, 0);
    push_request(KIND_UPDATE, 500, 16, 8, 8192, 8192);
    push_request(KIND_UPDATE, 12345, 1, 1, 1, 1);
    push_request(KIND_LIST, 0, 0, 0, 0, 0);
    push_request(KIND_REMOVE, 0, 0, 0, 0, 0);
    push_request(KIND_REMOVE, KEY_MAX, 0, 0, 0, 0);
    push_request(KIND_REMOVE, 250, 0, 0, 0, 0);
    push_request(3'd5, 500, 0, 0, 0, 0);
    push_request(3'd6, 999999, 0, 0, 0, 0);
    push_request(3'd7, KEY_MAX, 31, 15, 16383, 16383);
    push_request(KIND_LIST, 0, 0, 0, 0, 0);
    push_request(KIND_SEARCH, 0, 0, 0, 0, 0);

    made = 0;
    mood = FILL;
    full_left = FULL_RETRIES;
    mix_left = MIX_LENGTH;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // No gaps, then mostly gaps, then occasional gaps.
      sender_idle_pct = (phase == 1) ? 79 : (phase == 2) ? 16 : 0;
      while (made < (phase + 1) * RANDOM_REQUESTS / NUM_PHASES) begin
        case (mood)
          FILL: begin
            ins_pct = 85;
            rem_pct = 3;
          end
          DRAIN: begin
            ins_pct = 5;
            rem_pct = 78;
          end
          default: begin
            ins_pct = 30;
            rem_pct = 25;
          end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 3) kind = KindW'($urandom_range(5, 7));
        else if (roll < 3 + ins_pct) kind = KIND_INSERT;
        else if (roll < 3 + ins_pct + rem_pct) kind = KIND_REMOVE;
        else if (roll < 97) kind = roll[0] ? KIND_SEARCH : KIND_UPDATE;
        else kind = KIND_LIST;

        // Inserts are mostly fresh keys; on a full table half of them are
        // duplicates so that the full check is seen to come first.
        if (kind == KIND_INSERT) key = pick_key(live_keys.size() == TABLE_DEPTH ? 50 : 12);
        else key = pick_key(80);
        push_request(kind, key, $urandom_range(0, 31), $urandom_range(0, 15),
                     $urandom_range(0, 16383), $urandom_range(0, 16383));
        if (kind <= KIND_LIST) made++;

        case (mood)
          FILL: begin
            if (live_keys.size() == TABLE_DEPTH) begin
              if (full_left == 0) mood = DRAIN;
              else full_left--;
            end
          end
          DRAIN: begin
            if (live_keys.size() == 0) begin
              mood = MIX;
              mix_left = MIX_LENGTH;
            end
          end
          default: begin
            mix_left--;
            if (mix_left == 0) begin
              mood = FILL;
              full_left = FULL_RETRIES;
            end
          end
        endcase
      end
      while (open_requests != 0 || expected_reports.size() != 0) @(posedge clk_i);
    end

    // A dropped kind code or a final list may still keep the table busy.
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    if (!failed && expected_reports.size() == 0) begin
      $display("[sorted_key_record_table] OK");
    end else begin
      $display("[sorted_key_record_table] ERROR");
    end
    $finish;
  end

endmodule
